// ===== rtl/cfbc_pkg.sv =====
// Shared constants and a helper for the command frame builder.
// Field widths, header sync bytes, step codes and the checksum byte step.
// No dependencies.
`timescale 1ns / 1ps

package cfbc_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InDataW = 56;   // code, length, id, payload byte
  localparam int unsigned StepW   = 4;    // up to ten bytes per run

  localparam logic [ByteW-1:0] SYNC_HI  = 8'h53;
  localparam logic [ByteW-1:0] SYNC_LO  = 8'h74;
  localparam logic [WordW-1:0] CRC_POLY = 16'h8005;

  // cmd codes, carried on the slave tuser
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // step positions within a run
  localparam logic [StepW-1:0] STEP_FIRST       = 4'd0;
  localparam logic [StepW-1:0] STEP_HDR_LAST    = 4'd7;
  localparam logic [StepW-1:0] STEP_HDR_CRC_HI  = 4'd8;
  localparam logic [StepW-1:0] STEP_HDR_CRC_LO  = 4'd9;
  localparam logic [StepW-1:0] STEP_PLD_CRC_HI  = 4'd1;
  localparam logic [StepW-1:0] STEP_PLD_CRC_LO  = 4'd2;

  // One byte into the checksum: shift with feedback, then xor {prior, byte}.
  function automatic logic [WordW-1:0] crc_step(input logic [WordW-1:0] crc,
                                                 input logic [ByteW-1:0] prior,
                                                 input logic [ByteW-1:0] b);
    logic [WordW-1:0] sh;
    sh = {crc[WordW-2:0], 1'b0} ^ (crc[WordW-1] ? CRC_POLY : '0);
    return sh ^ {prior, b};
  endfunction

endpackage

// ===== rtl/command_frame_builder_crc16_core.sv =====
// Command frame builder: top level.
// Serializes start and payload items into framed bytes with a 16-bit checksum.
// Depends on cfbc_pkg.
`timescale 1ns / 1ps

// A start item (tuser = 0) produces the eight header bytes, plus the two
// checksum bytes when the payload length is zero. Each payload item
// (tuser = 1) produces one byte, and three (byte, checksum high, checksum
// low) for the final payload byte of a frame. The output runs at one byte
// per cycle while items keep arriving and the receiver keeps up; the step
// counter walks the held item through its bytes. The next item is taken in
// the cycle the held item's last byte moves into the output register, so
// payload items stream at one per cycle; a stalled output stalls the input.
// Stray payload gives one zero byte with tuser (error) set; a start while a
// frame is open flags error on its first header byte.
module command_frame_builder_crc16_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] command_code, [31:16] payload_length, [47:32] frame_id,
  // [55:48] payload_byte
  input  logic [55:0] s_axis_tdata,
  // [0] cmd
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,   // last_byte
  // [0] error
  output logic [0:0]  m_axis_tuser
);

  // held item
  logic                            hold_valid;
  logic                            hold_cmd;
  logic [cfbc_pkg::WordW-1:0]      hold_code;
  logic [cfbc_pkg::WordW-1:0]      hold_len;
  logic [cfbc_pkg::WordW-1:0]      hold_id;
  logic [cfbc_pkg::ByteW-1:0]      hold_byte;
  logic [cfbc_pkg::StepW-1:0]      step;

  // frame state
  logic [cfbc_pkg::WordW-1:0]      crc_accum, crc_accum_next;
  logic [cfbc_pkg::ByteW-1:0]      prior_byte, prior_byte_next;
  logic [cfbc_pkg::WordW-1:0]      bytes_left, bytes_left_next;
  logic                            frame_open, frame_open_next;

  logic                            fire, in_accept;
  logic [cfbc_pkg::ByteW-1:0]      cur_byte;
  logic                            cur_last, cur_err;
  logic [cfbc_pkg::ByteW-1:0]      hdr_byte;
  logic [cfbc_pkg::WordW-1:0]      crc_base;
  logic [cfbc_pkg::ByteW-1:0]      prior_base;

  assign fire          = hold_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !hold_valid || (fire && cur_last);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (step[2:0])
      3'd0:    hdr_byte = cfbc_pkg::SYNC_HI;
      3'd1:    hdr_byte = cfbc_pkg::SYNC_LO;
      3'd2:    hdr_byte = hold_code[15:8];
      3'd3:    hdr_byte = hold_code[7:0];
      3'd4:    hdr_byte = hold_len[15:8];
      3'd5:    hdr_byte = hold_len[7:0];
      3'd6:    hdr_byte = hold_id[15:8];
      default: hdr_byte = hold_id[7:0];
    endcase
  end

  // a new frame starts its checksum from zero
  assign crc_base   = (hold_cmd == cfbc_pkg::CMD_START && step == cfbc_pkg::STEP_FIRST)
                      ? '0 : crc_accum;
  assign prior_base = (hold_cmd == cfbc_pkg::CMD_START && step == cfbc_pkg::STEP_FIRST)
                      ? '0 : prior_byte;

  always_comb begin
    cur_byte        = '0;
    cur_last        = 1'b0;
    cur_err         = 1'b0;
    crc_accum_next  = crc_accum;
    prior_byte_next = prior_byte;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    if (hold_cmd == cfbc_pkg::CMD_START) begin
      if (step <= cfbc_pkg::STEP_HDR_LAST) begin
        cur_byte        = hdr_byte;
        cur_last        = (step == cfbc_pkg::STEP_HDR_LAST) && (hold_len != '0);
        cur_err         = (step == cfbc_pkg::STEP_FIRST) && frame_open;
        crc_accum_next  = cfbc_pkg::crc_step(crc_base, prior_base, hdr_byte);
        prior_byte_next = hdr_byte;
        if (step == cfbc_pkg::STEP_FIRST) begin
          frame_open_next = 1'b1;
          bytes_left_next = hold_len;
        end
      end else if (step == cfbc_pkg::STEP_HDR_CRC_HI) begin
        cur_byte = crc_accum[15:8];
      end else begin
        cur_byte        = crc_accum[7:0];
        cur_last        = 1'b1;
        frame_open_next = 1'b0;
        bytes_left_next = '0;
      end
    end else begin
      if (step == cfbc_pkg::STEP_FIRST) begin
        if (!frame_open || bytes_left == '0) begin
          // stray payload: zero byte, error, state untouched
          cur_last = 1'b1;
          cur_err  = 1'b1;
        end else begin
          cur_byte        = hold_byte;
          cur_last        = (bytes_left != 16'd1);
          crc_accum_next  = cfbc_pkg::crc_step(crc_accum, prior_byte, hold_byte);
          prior_byte_next = hold_byte;
          bytes_left_next = bytes_left - 16'd1;
        end
      end else if (step == cfbc_pkg::STEP_PLD_CRC_HI) begin
        cur_byte = crc_accum[15:8];
      end else begin
        cur_byte        = crc_accum[7:0];
        cur_last        = 1'b1;
        frame_open_next = 1'b0;
        bytes_left_next = '0;
      end
    end
  end

  // input register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      step       <= '0;
    end else if (in_accept) begin
      hold_valid <= 1'b1;
      step       <= '0;
    end else if (fire) begin
      if (cur_last) begin
        hold_valid <= 1'b0;
        step       <= '0;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_cmd  <= s_axis_tuser[0];
      hold_code <= s_axis_tdata[15:0];
      hold_len  <= s_axis_tdata[31:16];
      hold_id   <= s_axis_tdata[47:32];
      hold_byte <= s_axis_tdata[55:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum  <= '0;
      prior_byte <= '0;
      bytes_left <= '0;
      frame_open <= 1'b0;
    end else if (fire) begin
      crc_accum  <= crc_accum_next;
      prior_byte <= prior_byte_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata    <= cur_byte;
      m_axis_tlast    <= cur_last;
      m_axis_tuser[0] <= cur_err;
    end
  end

  // an error item is either a stray zero byte or the first sync byte of a restart
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata == '0 && m_axis_tlast) ||
      (m_axis_tdata == cfbc_pkg::SYNC_HI && !m_axis_tlast))
    else $error("malformed error item");

  a_left_needs_open: assert property (@(posedge clk) disable iff (rst)
    bytes_left != '0 |-> frame_open)
    else $error("payload count outside an open frame");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> step <= cfbc_pkg::STEP_HDR_CRC_LO)
    else $error("step counter overran a run");

  a_take_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && cur_last && !in_accept |=> !hold_valid)
    else $error("held item kept after its last byte");

endmodule
